### sv/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/ist_pkg.sv
// Types and constants of the integer set table.
package ist_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ELEM_W   = 32;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_CONTAINS = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    action_e                   action;
    logic signed [ELEM_W-1:0]  element;
  } in_t;

  typedef struct packed {
    logic success;
    logic table_full;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ELEM_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic commit;
    logic all_valid;
  } status_t;

endpackage

### sv/ist_value_ram.sv
// Value store: one write port, one registered read port.
module ist_value_ram (
  input  logic                     clk_i,
  input  ist_pkg::ram_req_t        req_i,
  output logic [ist_pkg::ELEM_W-1:0] rdata_o
);
  import ist_pkg::*;

  logic [ELEM_W-1:0] mem_q [CAPACITY];
  logic [ELEM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ist_ctrl.sv
// Sequencer, shared compare unit, valid marks and result register.
module ist_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ist_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ist_pkg::out_t              out_data_o,
  output ist_pkg::ram_req_t          ram_req_o,
  input  logic [ist_pkg::ELEM_W-1:0] ram_rdata_i,
  output ist_pkg::status_t           status_o
);
  import ist_pkg::*;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic              cmp_act_q, cmp_act_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  action_e           act_q;
  logic [ELEM_W-1:0] elem_q;
  logic              hit_q, free_q;
  logic [IDX_W-1:0]  hit_idx_q, free_idx_q;
  logic [CAPACITY-1:0] valid_q;
  logic              out_valid_q;
  out_t              out_q, res;
  logic              load, commit, scan_rd;
  logic              match, empty;

  // next state and sequencing
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    load    = 1'b0;
    commit  = 1'b0;
    scan_rd = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load    = 1'b1;
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_rd = 1'b1;
        cnt_d   = cnt_q + IDX_W'(1);
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmp_act_d = scan_rd;
  assign cmp_idx_d = cnt_q;

  // shared compare: one entry per cycle; the index is registered to line up with the registered read data
  assign match = cmp_act_q && valid_q[cmp_idx_q] && (ram_rdata_i == elem_q);
  assign empty = cmp_act_q && !valid_q[cmp_idx_q];

  always_comb begin
    res = '0;
    case (act_q)
      ACT_ADD: begin
        if (!hit_q) begin
          res.success    = free_q;
          res.table_full = !free_q;
        end
      end
      ACT_REMOVE:   res.success = hit_q;
      ACT_CONTAINS: res.success = hit_q;
      default:      res = '0;
    endcase
  end

  always_comb begin
    ram_req_o.we    = commit && (act_q == ACT_ADD) && !hit_q && free_q;
    ram_req_o.waddr = free_idx_q;
    ram_req_o.wdata = elem_q;
    ram_req_o.raddr = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cmp_act_q   <= 1'b0;
      cmp_idx_q   <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_act_q <= cmp_act_d;
      cmp_idx_q <= cmp_idx_d;
      if (load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (empty && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (commit) begin
        if ((act_q == ACT_ADD) && !hit_q && free_q) begin
          valid_q[free_idx_q] <= 1'b1;
        end else if ((act_q == ACT_REMOVE) && hit_q) begin
          valid_q[hit_idx_q] <= 1'b0;
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      act_q  <= in_data_i.action;
      elem_q <= in_data_i.element;
    end
    if (match && !hit_q) begin
      hit_idx_q <= cmp_idx_q;
    end
    if (empty && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (commit) begin
      out_q <= res;
    end
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign status_o.commit    = commit;
  assign status_o.all_valid = &valid_q;

endmodule

### sv/integer_set_table.sv
// Top level of the integer set table: bounded set of 32-bit integers.
//
//   channel | signals                        | payload
//   --------+--------------------------------+-----------------------------
//   in      | in_valid_i / in_ready_o        | in_data_i  (action, element)
//   out     | out_valid_o / out_ready_i      | out_data_o (success, table_full)
//
// Each transfer in is scanned against all CAPACITY entries, one entry per
// cycle through a single comparator fed by the value store's read port.
// An item goes through accept, a scan of every entry, a read drain and a
// commit, which may hold, before the block is ready for the next item.
// The result sits in an output register; a new item may be taken while it
// waits, and the commit of that next item holds until the register frees.
// Reset clears every valid mark at once; stored values need no clearing.
module integer_set_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ist_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ist_pkg::out_t   out_data_o
);
  import ist_pkg::*;

  `include "assert_macros.svh"

  ram_req_t          ram_req;
  logic [ELEM_W-1:0] ram_rdata;
  status_t           status;

  // Value store: written on a successful add, read by the scan counter.
  ist_value_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Sequencer with the shared comparator, valid marks and result register.
  ist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .status_o    (status)
  );

  // A transfer in starts a scan: not ready again in the next cycle.
  `ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A commit always leaves a result waiting.
  `ASSERT_NEXT(a_commit_shows, clk_i, rst_ni, status.commit, out_valid_o)
  // A refused add never also reports success.
  `ASSERT_IMPL(a_full_excl, clk_i, rst_ni, out_valid_o && out_data_o.table_full,
               !out_data_o.success)
  // Refusal only when every entry held a value.
  `ASSERT_NEXT(a_full_real, clk_i, rst_ni, status.commit && !status.all_valid,
               !out_data_o.table_full)

endmodule

### sim/ist_checker.sv
// Checker for the integer set table: tracks set contents and compares every result.
`timescale 1ns / 100ps

module ist_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  ist_pkg::in_t   in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  ist_pkg::out_t  out_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import ist_pkg::*;

  localparam int REPORT_MAX = 10;

  // Shadow copy of the set.
  logic [ELEM_W-1:0] slot_value [CAPACITY];
  logic              slot_used  [CAPACITY];

  out_t expected_q [$];
  int   mismatches = 0;
  out_t got_res;
  out_t want_res;

  // Applies one request to the shadow set and returns the answer it earns.
  function automatic out_t apply_request(input in_t req);
    out_t res;
    int   hit;
    int   free_slot;
    res       = '0;
    hit       = -1;
    free_slot = -1;
    // Walk downward so both indexes end at the lowest qualifying entry.
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (slot_used[i] && (slot_value[i] == req.element)) hit = i;
      if (!slot_used[i]) free_slot = i;
    end
    case (req.action)
      ACT_ADD: begin
        if (hit < 0) begin
          if (free_slot >= 0) begin
            slot_value[free_slot] = req.element;
            slot_used[free_slot]  = 1'b1;
            res.success           = 1'b1;
          end else begin
            res.table_full = 1'b1;
          end
        end
      end
      ACT_REMOVE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          res.success    = 1'b1;
        end
      end
      ACT_CONTAINS: begin
        res.success = (hit >= 0);
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
      expected_q.delete();
    end else begin
      // Push before pop: a result can never belong to the request taken this edge.
      if (in_valid_i && in_ready_i) expected_q.push_back(apply_request(in_data_i));
      if (out_valid_i && out_ready_i) begin
        got_res = out_data_i;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result with none pending: success %0b table_full %0b",
                     $realtime, got_res.success, got_res.table_full);
        end else begin
          want_res = expected_q.pop_front();
          if ((got_res.success !== want_res.success) ||
              (got_res.table_full !== want_res.table_full)) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: mismatch: success exp %0b got %0b, table_full exp %0b got %0b",
                       $realtime, want_res.success, got_res.success,
                       want_res.table_full, got_res.table_full);
          end
        end
      end
    end
    pending_o    <= expected_q.size();
    fail_count_o <= mismatches;
  end

endmodule

### sim/tb_integer_set_table.sv
// Testbench top for the integer set table: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_integer_set_table;
  import ist_pkg::*;

  // Action code with no enum member; the block must ignore it.
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  localparam int ITEMS_PER_PHASE = 450;
  localparam int NUM_PHASES      = 4;
  localparam int POOL_SIZE       = 24;
  localparam int DRAIN_CYCLES    = 2 * (CAPACITY + 3);
  localparam int CYCLE_LIMIT     = 400000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int fail_count;
  int pending;
  int cycle_cnt = 0;

  // Idle rates in percent, changed per phase.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Small value pool so adds, removes and lookups keep hitting each other.
  logic [ELEM_W-1:0] elem_pool [POOL_SIZE];

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_set_table DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  ist_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver back-pressure: one fresh decision every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_t make_req(input logic [1:0] act, input logic [ELEM_W-1:0] value);
    in_t req;
    req.action  = action_e'(act);
    req.element = value;
    return req;
  endfunction

  // Offers one request and returns at the edge where the transfer happens.
  // Valid only drops on an idle cycle, so back-to-back transfers keep it high.
  task automatic send_transfer(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds off the sender until every outstanding result has been seen.
  // The first edge lets the checker count the last transfer.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random request: mostly pool values, some fully random words.
  task automatic send_random_req();
    int                r;
    logic [1:0]        act;
    logic [ELEM_W-1:0] value;
    r = $urandom_range(99);
    if (r < 40)      act = ACT_ADD;
    else if (r < 70) act = ACT_REMOVE;
    else if (r < 95) act = ACT_CONTAINS;
    else             act = ACT_UNKNOWN;
    if ($urandom_range(99) < 85) value = elem_pool[$urandom_range(POOL_SIZE - 1)];
    else                         value = $urandom;
    send_transfer(make_req(act, value));
  endtask

  initial begin
    // Pool: extremes, single-bit neighbors, then random words.
    elem_pool[0] = 32'h0000_0000;
    elem_pool[1] = 32'hFFFF_FFFF;
    elem_pool[2] = 32'h8000_0000;
    elem_pool[3] = 32'h7FFF_FFFF;
    elem_pool[4] = 32'h0000_0001;
    elem_pool[5] = 32'h8000_0001;
    elem_pool[6] = 32'h5555_5555;
    elem_pool[7] = 32'hAAAA_AAAA;
    for (int i = 8; i < POOL_SIZE; i++) elem_pool[i] = $urandom;

    // Reset is held first; the valid marks clear here.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling.
    send_transfer(make_req(ACT_CONTAINS, 32'h0000_0000));  // lookup in empty set
    send_transfer(make_req(ACT_REMOVE, 32'h0000_0005));    // remove of absent value
    send_transfer(make_req(ACT_ADD, 32'h8000_0000));
    send_transfer(make_req(ACT_ADD, 32'h7FFF_FFFF));
    send_transfer(make_req(ACT_ADD, 32'hFFFF_FFFF));
    send_transfer(make_req(ACT_ADD, 32'h8000_0000));       // duplicate add
    send_transfer(make_req(ACT_CONTAINS, 32'h7FFF_FFFF));
    send_transfer(make_req(ACT_REMOVE, 32'hFFFF_FFFF));
    send_transfer(make_req(ACT_UNKNOWN, 32'h8000_0000));   // ignored, set unchanged
    send_transfer(make_req(ACT_CONTAINS, 32'h8000_0000));
    // Fill the remaining fourteen entries.
    for (int v = 1; v <= CAPACITY - 2; v++) send_transfer(make_req(ACT_ADD, v));
    send_transfer(make_req(ACT_ADD, 32'h0000_0000));       // refused, set full
    send_transfer(make_req(ACT_ADD, 32'h7FFF_FFFF));       // duplicate while full
    send_transfer(make_req(ACT_REMOVE, 32'h8000_0000));
    send_transfer(make_req(ACT_ADD, 32'h0000_0000));       // takes the freed entry

    // Random phases with different flow-control mixes; drain between them.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 72; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_req();
    end

    // Drain, then allow a few item times for any stray result.
    wait_drained();
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if ((fail_count == 0) && (pending == 0)) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### integer_set_table.f
+incdir+sv
sv/ist_pkg.sv
sv/ist_value_ram.sv
sv/ist_ctrl.sv
sv/integer_set_table.sv
sim/ist_checker.sv
sim/tb_integer_set_table.sv
